// ===== src/ssms_pkg.sv =====
// Shared constants, types and the message segment table of the scrolling display.
package ssms_pkg;

  localparam int DISPLAY_COUNT = 6;
  localparam int DIGIT_COUNT = 6;
  localparam int WRAP_POSITION = 20;
  localparam int MSG_LEN = 26;
  localparam int SEG_W = 7;
  localparam int KEY_W = 4;
  localparam int PERIOD_W = 32;
  localparam int POS_W = $clog2(WRAP_POSITION + 1);
  localparam int IDX_W = $clog2(WRAP_POSITION + DISPLAY_COUNT + 1);
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(50000000);

  localparam int KEY_PAUSE = 0;
  localparam int KEY_FASTER = 1;
  localparam int KEY_SLOWER = 2;
  localparam int KEY_REVERSE = 3;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'b0000000;
  localparam logic [SEG_W-1:0] SEG_U = 7'b0111110;
  localparam logic [SEG_W-1:0] SEG_O = 7'b1011100;
  localparam logic [SEG_W-1:0] SEG_F = 7'b1110001;
  localparam logic [SEG_W-1:0] SEG_T = 7'b1111000;
  localparam logic [SEG_W-1:0] SEG_E = 7'b1111001;
  localparam logic [SEG_W-1:0] SEG_C = 7'b0111001;
  localparam logic [SEG_W-1:0] SEG_2 = 7'b1011011;
  localparam logic [SEG_W-1:0] SEG_4 = 7'b1100110;
  localparam logic [SEG_W-1:0] SEG_3 = 7'b1001111;
  localparam logic [SEG_W-1:0] SEG_DASH = 7'b1000000;

  typedef logic [DISPLAY_COUNT-1:0][SEG_W-1:0] seg_row_t;

  // Segment code of one message character; indexes past the end are blank.
  function automatic logic [SEG_W-1:0] seg_at(input logic [IDX_W-1:0] idx);
    logic [SEG_W-1:0] code;
    unique case (idx)
      IDX_W'(0):  code = SEG_U;
      IDX_W'(2):  code = SEG_O;
      IDX_W'(3):  code = SEG_F;
      IDX_W'(5):  code = SEG_T;
      IDX_W'(7):  code = SEG_E;
      IDX_W'(8):  code = SEG_C;
      IDX_W'(9):  code = SEG_E;
      IDX_W'(10): code = SEG_DASH;
      IDX_W'(11): code = SEG_2;
      IDX_W'(12): code = SEG_4;
      IDX_W'(13): code = SEG_3;
      IDX_W'(20): code = SEG_U;
      IDX_W'(22): code = SEG_O;
      IDX_W'(23): code = SEG_F;
      IDX_W'(25): code = SEG_T;
      default:    code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== src/ssms_display.sv =====
// Message table lookup that turns a window position into six segment codes.
module ssms_display
  import ssms_pkg::*;
(
  input  logic [POS_W-1:0] position,
  output seg_row_t         row
);

  always_comb begin
    for (int k = 0; k < DISPLAY_COUNT; k++) begin
      if (k < DIGIT_COUNT) begin
        row[k] = seg_at(IDX_W'(position) + IDX_W'(k));
      end else begin
        row[k] = SEG_BLANK;
      end
    end
  end

endmodule

// ===== src/seven_segment_message_scroller.sv =====
// Top level of the scrolling message display: countdown, key handling and result register.
//
// Each input item is one tick carrying key_edges, new key presses ORed into a
// pending set. The block counts ticks down from the scroll period; when the
// count expires the displays move to the next window of the message, the
// position steps forward or backward unless scrolling is paused, and one
// pending key is served, lowest bit first (pause, faster, slower, reverse).
// Every accepted item produces exactly one result item: the six segment codes
// and step_done, which is high for the tick in which the period expired.
// out_valid rises in the cycle after acceptance, and one item can be accepted
// in every cycle while the receiver does not stall; the state update and table
// lookup sit between the state registers and the result register.
// When the receiver stalls, the result register holds its item and in_stall
// rises until the item is taken.
// A write on cfg_write loads the scroll period and the countdown at once; zero
// is taken as one. Write it only while no item is in flight.
// Synchronous reset sets the period to 50000000, shows position 0 and empties
// the result register.
module seven_segment_message_scroller
  import ssms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    key_edges,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SEG_W-1:0]    digit5_code,
  output logic [SEG_W-1:0]    digit4_code,
  output logic [SEG_W-1:0]    digit3_code,
  output logic [SEG_W-1:0]    digit2_code,
  output logic [SEG_W-1:0]    digit1_code,
  output logic [SEG_W-1:0]    digit0_code,
  output logic                step_done
);

  logic [POS_W-1:0]    shown_position, shown_position_next;
  logic [POS_W-1:0]    next_position, next_position_next;
  logic                scroll_enabled, scroll_enabled_next;
  logic                direction_forward, direction_forward_next;
  logic [PERIOD_W-1:0] scroll_period, scroll_period_next;
  logic [PERIOD_W-1:0] cycles_left, cycles_left_next;
  logic [KEY_W-1:0]    pending_keys, pending_keys_next;
  logic [KEY_W-1:0]    keys_all;
  logic                expired;
  logic                accept_in;
  logic [PERIOD_W-1:0] cfg_period;
  seg_row_t            row;

  assign in_stall = out_valid && out_stall;
  assign accept_in = in_valid && !in_stall;
  assign cfg_period = (cfg_data == '0) ? PERIOD_W'(1) : cfg_data;

  always_comb begin
    keys_all = pending_keys | key_edges;
    expired = (cycles_left[PERIOD_W-1:1] == '0);
    shown_position_next = shown_position;
    next_position_next = next_position;
    scroll_enabled_next = scroll_enabled;
    direction_forward_next = direction_forward;
    scroll_period_next = scroll_period;
    pending_keys_next = keys_all;
    cycles_left_next = cycles_left - PERIOD_W'(1);
    if (expired) begin
      shown_position_next = next_position;
      if (scroll_enabled) begin
        if (direction_forward) begin
          if ((POS_W + 1)'(next_position) + (POS_W + 1)'(1) >= (POS_W + 1)'(WRAP_POSITION)) begin
            next_position_next = '0;
          end else begin
            next_position_next = next_position + POS_W'(1);
          end
        end else begin
          if (next_position <= POS_W'(1)) begin
            next_position_next = POS_W'(WRAP_POSITION);
          end else begin
            next_position_next = next_position - POS_W'(1);
          end
        end
      end
      priority if (keys_all[KEY_PAUSE]) begin
        scroll_enabled_next = !scroll_enabled;
        pending_keys_next[KEY_PAUSE] = 1'b0;
      end else if (keys_all[KEY_FASTER]) begin
        scroll_period_next = (scroll_period[PERIOD_W-1:1] == '0) ? PERIOD_W'(1)
                                                                  : (scroll_period >> 1);
        pending_keys_next[KEY_FASTER] = 1'b0;
      end else if (keys_all[KEY_SLOWER]) begin
        scroll_period_next = scroll_period[PERIOD_W-1] ? '1 : (scroll_period << 1);
        pending_keys_next[KEY_SLOWER] = 1'b0;
      end else if (keys_all[KEY_REVERSE]) begin
        direction_forward_next = !direction_forward;
        pending_keys_next[KEY_REVERSE] = 1'b0;
      end else begin
        pending_keys_next = keys_all;
      end
      cycles_left_next = scroll_period_next;
    end
  end

  ssms_display u_display (
    .position (shown_position_next),
    .row      (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_position <= '0;
      next_position <= POS_W'(1);
      scroll_enabled <= 1'b1;
      direction_forward <= 1'b1;
      scroll_period <= RESET_PERIOD;
      cycles_left <= RESET_PERIOD;
      pending_keys <= '0;
    end else if (cfg_write) begin
      scroll_period <= cfg_period;
      cycles_left <= cfg_period;
    end else if (accept_in) begin
      shown_position <= shown_position_next;
      next_position <= next_position_next;
      scroll_enabled <= scroll_enabled_next;
      direction_forward <= direction_forward_next;
      scroll_period <= scroll_period_next;
      cycles_left <= cycles_left_next;
      pending_keys <= pending_keys_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_in) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      digit5_code <= row[0];
      digit4_code <= row[1];
      digit3_code <= row[2];
      digit2_code <= row[3];
      digit1_code <= row[4];
      digit0_code <= row[5];
      step_done <= expired;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) scroll_period != '0)
    else $error("scroll period reached zero");

  assert property (@(posedge clk) disable iff (rst)
    next_position <= POS_W'(WRAP_POSITION) && shown_position <= POS_W'(WRAP_POSITION))
    else $error("scroll position beyond wrap point");

  assert property (@(posedge clk) disable iff (rst)
    (accept_in && expired && !cfg_write) |=> (cycles_left == scroll_period))
    else $error("countdown not reloaded from period on expiry");

  assert property (@(posedge clk) disable iff (rst)
    (accept_in && !expired && !cfg_write) |=> (shown_position == $past(shown_position)))
    else $error("position moved without expiry");
`endif

endmodule
